>>> sv/srsp_pkg.sv
// ----------------------------------------------------------------------------
// srsp_pkg - shared definitions for the stereo ring sample player
// Ring geometry, phase format, stream widths, request and register codes.
// ----------------------------------------------------------------------------
package srsp_pkg;

    // ring depth per channel (power of two) and phase fraction bits
    localparam int RING_DEPTH = 8192;
    localparam int FRAC_BITS  = 12;

    localparam int RING_AW  = $clog2(RING_DEPTH);
    localparam int PHASE_W  = RING_AW + FRAC_BITS;
    localparam int STEP_W   = FRAC_BITS + 1;   // rate*2^F/44100 < 2^(F+1)
    localparam int CHAN_BIT = 13;              // word_index bit that picks right

    localparam int OUT_RATE = 44100;

    // stream and config widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 1;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 16;
    localparam int SAMPLE_W  = 16;
    localparam int POS_W     = 13;

    // phase step = floor(rate * 2^F / OUT_RATE) as one multiply by an exact
    // rounded-up reciprocal (dividend below 2^DIV_N)
    localparam int DIV_N    = CFG_DW + FRAC_BITS;
    localparam int DIV_L    = $clog2(OUT_RATE);
    localparam int DIV_S    = DIV_N + DIV_L;
    localparam int RECIP_W  = DIV_N + 1;
    localparam int STEP_SH  = DIV_S - FRAC_BITS;
    localparam longint unsigned STEP_RECIP =
        ((64'd1 << DIV_S) + 64'(OUT_RATE) - 64'd1) / 64'(OUT_RATE);

    localparam int ROUND_ADD = (1 << (FRAC_BITS - 1)) - 1;

    typedef enum logic [S_TUSER_W-1:0] {
        REQ_WRITE  = 3'd0,
        REQ_READ   = 3'd1,
        REQ_SETPOS = 3'd2,
        REQ_RDPOS  = 3'd3,
        REQ_TICK   = 3'd4
    } t_req_e;

    typedef enum logic [CFG_AW-1:0] {
        CFG_PLAY_RATE  = 2'd0,
        CFG_LEFT_GAIN  = 2'd1,
        CFG_RIGHT_GAIN = 2'd2
    } t_cfg_e;

endpackage

>>> sv/srsp_ram.sv
// ----------------------------------------------------------------------------
// srsp_ram - generic single-port RAM
// A write, a read or both per cycle; read data registered, held while idle.
// ----------------------------------------------------------------------------
module srsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

>>> sv/stereo_ring_sample_player.sv
// ----------------------------------------------------------------------------
// stereo_ring_sample_player - stereo wavetable ring with phase playback
// Ring access, play position control and gain-scaled stereo output ticks.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps both channel RAMs to zero, one word per
// cycle over RING_DEPTH (8192) words, with s_tready low; config writes are
// taken during the sweep. After that it takes one request per cycle while the
// output side keeps up and returns exactly one result transfer per request
// via the RAM read stage and output register. Throughput is one item per
// cycle, set by the single RAM port per channel (one access per item) and
// the phase register that every tick reads and updates in the accept cycle.
// A stalled result is held in the output register while one more request
// can still be taken into the RAM read stage.
// ----------------------------------------------------------------------------
module stereo_ring_sample_player (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: word_index[13:0], sample_value[29:14], position_value[42:30], zero
    input  logic [srsp_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: req_type[2:0]
    input  logic [srsp_pkg::S_TUSER_W-1:0] s_tuser,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata: ring_word[15:0], play_position[28:16], left_out[44:29],
    //        right_out[60:45], zero
    output logic [srsp_pkg::M_TDATA_W-1:0] m_tdata,
    // tuser: audio_valid[0]
    output logic [srsp_pkg::M_TUSER_W-1:0] m_tuser,
    // config write port
    input  logic                           i_cfg_we,
    input  logic [srsp_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [srsp_pkg::CFG_DW-1:0]    i_cfg_data
);

    import srsp_pkg::*;

    // ---------------- request fields ----------------
    t_req_e                 w_req;
    logic [13:0]            w_word_index;
    logic [SAMPLE_W-1:0]    w_sample;
    logic [POS_W-1:0]       w_pos;

    assign w_req        = t_req_e'(s_tuser);
    assign w_word_index = s_tdata[13:0];
    assign w_sample     = s_tdata[29:14];
    assign w_pos        = s_tdata[42:30];

    // ---------------- control / state registers ----------------
    logic                   r_clr_busy;
    logic [RING_AW-1:0]     r_clr_addr;
    logic [PHASE_W-1:0]     r_phase, n_phase;
    logic [STEP_W-1:0]      r_phase_step;
    logic [CFG_DW-1:0]      r_left_gain;
    logic [CFG_DW-1:0]      r_right_gain;

    // RAM read stage
    logic                   r_s1_valid;
    t_req_e                 r_s1_req;
    logic                   r_s1_chan;
    logic [RING_AW-1:0]     r_s1_pos;

    // output register
    logic                   r_out_valid;
    logic [SAMPLE_W-1:0]    r_out_word;
    logic [POS_W-1:0]       r_out_pos;
    logic [SAMPLE_W-1:0]    r_out_left;
    logic [SAMPLE_W-1:0]    r_out_right;
    logic                   r_out_audio;

    logic                   w_acc;
    logic                   w_out_free;

    assign w_out_free = !r_out_valid || m_tready;
    assign s_tready   = !r_clr_busy && (!r_s1_valid || w_out_free);
    assign w_acc      = s_tvalid && s_tready;

    // ---------------- address generation ----------------
    logic [RING_AW-1:0]     w_ofs;
    logic [RING_AW-1:0]     w_pos_ofs;
    logic [PHASE_W-1:0]     w_round_sum;
    logic [RING_AW-1:0]     w_round_idx;
    logic                   w_chan;

    assign w_chan      = w_word_index[CHAN_BIT];
    assign w_ofs       = RING_AW'(32'(w_word_index[CHAN_BIT-1:0]) % 32'(RING_DEPTH));
    assign w_pos_ofs   = RING_AW'(32'(w_pos) % 32'(RING_DEPTH));
    // round to nearest index, ties go down; wraps with the ring
    assign w_round_sum = r_phase + PHASE_W'(ROUND_ADD);
    assign w_round_idx = w_round_sum[PHASE_W-1:FRAC_BITS];

    // ---------------- ring RAMs ----------------
    logic                   w_we_l, w_we_r, w_re;
    logic [RING_AW-1:0]     w_ram_addr;
    logic [SAMPLE_W-1:0]    w_ram_wdata;
    logic [SAMPLE_W-1:0]    w_rd_l, w_rd_r;

    always_comb begin
        w_ram_addr  = w_ofs;
        w_ram_wdata = w_sample;
        w_we_l      = 1'b0;
        w_we_r      = 1'b0;
        w_re        = w_acc;
        if (r_clr_busy) begin
            // zero sweep after reset
            w_ram_addr  = r_clr_addr;
            w_ram_wdata = '0;
            w_we_l      = 1'b1;
            w_we_r      = 1'b1;
        end else if (w_acc) begin
            unique case (w_req)
                REQ_WRITE: begin
                    w_we_l = !w_chan;
                    w_we_r = w_chan;
                end
                REQ_TICK: begin
                    w_ram_addr = w_round_idx;
                end
                default: begin
                end
            endcase
        end
    end

    srsp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ram_l (
        .i_clk   (i_clk),
        .i_we    (w_we_l),
        .i_re    (w_re),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_rd_l)
    );

    srsp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ram_r (
        .i_clk   (i_clk),
        .i_we    (w_we_r),
        .i_re    (w_re),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_rd_r)
    );

    // ---------------- phase accumulator ----------------
    always_comb begin
        n_phase = r_phase;
        if (w_acc) begin
            unique case (w_req)
                REQ_SETPOS: n_phase = {w_pos_ofs, {FRAC_BITS{1'b0}}};
                REQ_TICK:   n_phase = r_phase + PHASE_W'(r_phase_step);
                default:    n_phase = r_phase;
            endcase
        end
    end

    // ---------------- config ----------------
    // step is computed at write time: one multiply by the reciprocal
    logic [CFG_DW+RECIP_W-1:0] w_step_prod;

    assign w_step_prod = (CFG_DW+RECIP_W)'(i_cfg_data) *
                         (CFG_DW+RECIP_W)'(STEP_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_left_gain  <= CFG_DW'(256);
            r_right_gain <= CFG_DW'(256);
        end else if (i_cfg_we) begin
            unique case (t_cfg_e'(i_cfg_addr))
                CFG_PLAY_RATE:  r_phase_step <= w_step_prod[STEP_SH +: STEP_W];
                CFG_LEFT_GAIN:  r_left_gain  <= i_cfg_data;
                CFG_RIGHT_GAIN: r_right_gain <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ---------------- clear sweep, phase, read stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_phase    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == RING_AW'(RING_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_phase <= n_phase;
            if (w_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_out_free) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_req  <= w_req;
            r_s1_chan <= w_chan;
            r_s1_pos  <= w_round_idx;
        end
    end

    // ---------------- gain scaling ----------------
    function automatic logic [SAMPLE_W-1:0] sat_scale(input logic signed [32:0] prod);
        logic signed [32:0] q;
        begin
            q = prod >>> 8;   // floor divide by 256
            if (q > 33'sd32767) begin
                sat_scale = 16'h7FFF;
            end else if (q < -33'sd32768) begin
                sat_scale = 16'h8000;
            end else begin
                sat_scale = q[SAMPLE_W-1:0];
            end
        end
    endfunction

    logic signed [32:0] w_prod_l, w_prod_r;

    assign w_prod_l = 33'($signed(w_rd_l)) * $signed({17'd0, r_left_gain});
    assign w_prod_r = 33'($signed(w_rd_r)) * $signed({17'd0, r_right_gain});

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid) begin
            r_out_word  <= '0;
            r_out_pos   <= '0;
            r_out_left  <= '0;
            r_out_right <= '0;
            r_out_audio <= 1'b0;
            unique case (r_s1_req)
                REQ_READ:  r_out_word <= r_s1_chan ? w_rd_r : w_rd_l;
                REQ_RDPOS: r_out_pos  <= POS_W'(r_s1_pos);
                REQ_TICK: begin
                    r_out_left  <= sat_scale(w_prod_l);
                    r_out_right <= sat_scale(w_prod_r);
                    r_out_audio <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {3'b000, r_out_right, r_out_left, r_out_pos, r_out_word};
    assign m_tuser  = r_out_audio;

endmodule

>>> sv/srsp_checker.sv
// ----------------------------------------------------------------------------
// srsp_checker - port-level checks for the stereo ring sample player
// Reset sweep, result field exclusivity, latency and output hold.
// ----------------------------------------------------------------------------
module srsp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [srsp_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [srsp_pkg::M_TUSER_W-1:0] m_tuser
);

    import srsp_pkg::*;

    // reset starts the zero sweep: no request taken, no result shown
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_tready && !m_tvalid)
        else $error("request taken or result shown right after reset");

    // non-audio result leaves both scaled samples zero
    a_audio_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[60:29] == '0)
        else $error("scaled samples nonzero without audio_valid");

    // audio result leaves ring word and position zero
    a_audio_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[28:0] == '0)
        else $error("ring word or position nonzero on an output tick");

    // a transfer into an empty output side yields a result via s1 and out regs
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
        else $error("result missing after accepted request");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind stereo_ring_sample_player srsp_checker u_srsp_checker (.*);

>>> bench/ring_player_tb_pkg.sv
// ----------------------------------------------------------------------------
// ring_player_tb_pkg - request/result types and scoreboard for the ring player
// Holds a bit-exact model of the ring, the phase and the gain registers, and
// keeps the queue of results the block owes.
// ----------------------------------------------------------------------------
package ring_player_tb_pkg;
    import srsp_pkg::*;

    typedef struct packed {
        logic [2:0]          req_type;
        logic [13:0]         word_index;
        logic [15:0]         sample_value;
        logic [POS_W-1:0]    position_value;
    } t_ring_request;

    typedef struct packed {
        logic signed [15:0]  ring_word;
        logic [POS_W-1:0]    play_position;
        logic signed [15:0]  left_out;
        logic signed [15:0]  right_out;
        logic                audio_valid;
    } t_ring_result;

    class t_ring_player_scoreboard;
        logic [SAMPLE_W-1:0] ring_mem [0:2*RING_DEPTH-1];
        logic [PHASE_W-1:0]  phase;
        logic [CFG_DW-1:0]   rate;
        logic [CFG_DW-1:0]   gain_l;
        logic [CFG_DW-1:0]   gain_r;
        t_ring_result        owed_q [$];
        int                  mismatches;
        int                  n_req;
        int                  n_tick;
        int                  n_sat;
        int                  n_read;

        function new();
            foreach (ring_mem[k]) ring_mem[k] = '0;
            phase      = '0;
            rate       = 16'd0;
            gain_l     = 16'd256;
            gain_r     = 16'd256;
            mismatches = 0;
            n_req      = 0;
            n_tick     = 0;
            n_sat      = 0;
            n_read     = 0;
        endfunction

        function void set_reg(t_cfg_e idx, logic [CFG_DW-1:0] value);
            case (idx)
                CFG_PLAY_RATE:  rate   = value;
                CFG_LEFT_GAIN:  gain_l = value;
                CFG_RIGHT_GAIN: gain_r = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // phase rounded to the nearest ring index, wrapping at the ring end
        function logic [RING_AW-1:0] play_index();
            logic [PHASE_W:0] sum;
            sum = {1'b0, phase} + (PHASE_W+1)'(ROUND_ADD);
            return sum[FRAC_BITS +: RING_AW];
        endfunction

        // (sample * gain) >> 8 with floor, clamped to 16 bits signed
        function logic [SAMPLE_W-1:0] apply_gain(logic [SAMPLE_W-1:0] raw,
                                                 logic [CFG_DW-1:0] gain);
            longint prod;
            longint q;
            prod = longint'($signed(raw)) * longint'(gain);
            q = prod >>> 8;
            if (q > 32767) begin
                q = 32767;
                n_sat++;
            end else if (q < -32768) begin
                q = -32768;
                n_sat++;
            end
            return q[SAMPLE_W-1:0];
        endfunction

        function void note_request(t_ring_request rq);
            t_ring_result        res;
            logic [RING_AW-1:0]  idx;
            logic [STEP_W-1:0]   step;
            res = '0;
            n_req++;
            case (rq.req_type)
                REQ_WRITE: ring_mem[rq.word_index] = rq.sample_value;
                REQ_READ: begin
                    res.ring_word = ring_mem[rq.word_index];
                    n_read++;
                end
                REQ_SETPOS: phase = PHASE_W'(rq.position_value) << FRAC_BITS;
                REQ_RDPOS: res.play_position = play_index();
                REQ_TICK: begin
                    idx  = play_index();
                    step = STEP_W'((longint'(rate) << FRAC_BITS) / OUT_RATE);
                    res.left_out    = apply_gain(ring_mem[idx], gain_l);
                    res.right_out   = apply_gain(ring_mem[RING_DEPTH + idx], gain_r);
                    res.audio_valid = 1'b1;
                    phase  = phase + PHASE_W'(step);   // wraps at ring size
                    n_tick++;
                end
                default: ;   // unused codes: no state change, all-zero result
            endcase
            owed_q.push_back(res);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata,
                                   logic [M_TUSER_W-1:0] tuser);
            t_ring_result got;
            t_ring_result want;
            got.ring_word     = tdata[15:0];
            got.play_position = tdata[28:16];
            got.left_out      = tdata[44:29];
            got.right_out     = tdata[60:45];
            got.audio_valid   = tuser[0];
            if (owed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: tdata=%h tuser=%b", tdata, tuser);
                return;
            end
            want = owed_q.pop_front();
            if (got.ring_word !== want.ring_word ||
                got.play_position !== want.play_position ||
                got.left_out !== want.left_out ||
                got.right_out !== want.right_out ||
                got.audio_valid !== want.audio_valid) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp word=%0d pos=%0d L=%0d R=%0d av=%0b",
                              " | got word=%0d pos=%0d L=%0d R=%0d av=%0b"},
                             want.ring_word, want.play_position, want.left_out,
                             want.right_out, want.audio_valid, got.ring_word,
                             got.play_position, got.left_out, got.right_out,
                             got.audio_valid);
            end
        endfunction
    endclass

endpackage

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for the stereo ring sample player
// Directed ring, position and tick cases, then random request mixes under
// eight rate/gain settings and three idle patterns on both stream sides.
// ----------------------------------------------------------------------------
module tb;
    import srsp_pkg::*;
    import ring_player_tb_pkg::*;

    // Reset sweep alone is quiet while it clears all RING_DEPTH words; allow several times that.
    localparam int STALL_LIMIT = 40000;
    localparam int RAND_ITEMS  = 850;
    localparam int N_SETTINGS  = 8;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 s_tvalid   = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata    = '0;
    logic [S_TUSER_W-1:0] s_tuser    = '0;
    logic                 m_tvalid;
    logic                 m_tready   = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_AW-1:0]    i_cfg_addr = '0;
    logic [CFG_DW-1:0]    i_cfg_data = '0;

    t_ring_player_scoreboard sb = new();

    // percent of cycles each side holds off
    int src_idle = 6;
    int rcv_idle = 50;
    int quiet_cycles = 0;
    logic [RING_AW-1:0] hot_base = '0;   // window that writes, seeks and ticks share

    stereo_ring_sample_player DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Receiver back-pressure: one draw per cycle.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= rcv_idle);
    end

    // Result checking and the no-progress counter. Values read here are the
    // ones from before the edge, since every driver uses nonblocking updates.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Watchdog: nothing moving on either stream for too long.
    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("timeout: no transfer for %0d cycles, %0d results still owed",
                 STALL_LIMIT, sb.pending());
        $display("[FAIL] regression broken");
        $finish;
    end

    // One request transfer. Idle cycles come first; s_tvalid stays high
    // across back-to-back transfers so it is never lowered and raised in one
    // step. The request is handed to the scoreboard at its accept edge.
    task automatic send_request(input logic [2:0] kind, input logic [13:0] widx,
                                input logic [15:0] sval, input logic [POS_W-1:0] pos);
        t_ring_request rq;
        rq.req_type       = kind;
        rq.word_index     = widx;
        rq.sample_value   = sval;
        rq.position_value = pos;
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'd0, pos, sval, widx};
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(rq);
    endtask

    // Let every owed result come back before touching registers.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Register write; the enable is left high so a batch runs back to back.
    task automatic cfg_write(input t_cfg_e idx, input logic [CFG_DW-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.set_reg(idx, value);
    endtask

    task automatic apply_setting(input logic [CFG_DW-1:0] rate,
                                 input logic [CFG_DW-1:0] gl,
                                 input logic [CFG_DW-1:0] gr);
        drain();
        cfg_write(CFG_PLAY_RATE, rate);
        cfg_write(CFG_LEFT_GAIN, gl);
        cfg_write(CFG_RIGHT_GAIN, gr);
        i_cfg_we <= 1'b0;
    endtask

    // Random request. Most ring and position traffic lands near hot_base so
    // ticks play back samples that were actually written; the rest is spread
    // over the whole index range. Fields a request does not use stay random.
    task automatic send_random(output logic [2:0] kind);
        int unsigned        pick;
        logic [13:0]        widx;
        logic [15:0]        sval;
        logic [POS_W-1:0]   pos;
        pick = $urandom_range(99);
        widx = 14'($urandom);
        sval = 16'($urandom);
        pos  = 13'($urandom);
        if (pick < 30)      kind = REQ_WRITE;
        else if (pick < 40) kind = REQ_READ;
        else if (pick < 48) kind = REQ_SETPOS;
        else if (pick < 58) kind = REQ_RDPOS;
        else if (pick < 95) kind = REQ_TICK;
        else                kind = 3'($urandom_range(7, 5));
        if ($urandom_range(99) < 75) begin
            widx[12:0] = hot_base + 13'($urandom_range(127));
            pos        = hot_base + 13'($urandom_range(15));
        end
        send_request(kind, widx, sval, pos);
    endtask

    initial begin
        logic [CFG_DW-1:0] rate_set [N_SETTINGS];
        logic [CFG_DW-1:0] gl_set   [N_SETTINGS];
        logic [CFG_DW-1:0] gr_set   [N_SETTINGS];
        logic [2:0]        kind;
        int                done;
        int                per_set;

        // fixed settings first: nominal, extremes, tiny rate; rest random
        rate_set[0] = 16'd44100; gl_set[0] = 16'd256;   gr_set[0] = 16'd256;
        rate_set[1] = 16'hFFFF;  gl_set[1] = 16'd0;     gr_set[1] = 16'hFFFF;
        rate_set[2] = 16'd0;     gl_set[2] = 16'hFFFF;  gr_set[2] = 16'd0;
        rate_set[3] = 16'd1;     gl_set[3] = 16'd128;   gr_set[3] = 16'd512;
        for (int k = 4; k < N_SETTINGS; k++) begin
            rate_set[k] = 16'($urandom);
            gl_set[k]   = 16'($urandom_range(1023));
            gr_set[k]   = 16'($urandom);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register writes are taken during the post-reset clearing sweep.
        apply_setting(16'd0, 16'd256, 16'd256);

        // --- directed: ring extremes, read-back, zero rate, seek, bad codes
        send_request(REQ_WRITE, 14'h0000, 16'h7FFF, 13'h0000);
        send_request(REQ_WRITE, 14'h2000, 16'h8000, 13'h1FFF);
        send_request(REQ_WRITE, 14'h1FFF, 16'hFFFF, 13'h0000);
        send_request(REQ_WRITE, 14'h3FFF, 16'h1234, 13'h1FFF);
        send_request(REQ_READ,  14'h0000, 16'h0000, 13'h0000);
        send_request(REQ_READ,  14'h2000, 16'hFFFF, 13'h1FFF);
        send_request(REQ_READ,  14'h1FFF, 16'h0000, 13'h0000);
        send_request(REQ_READ,  14'h3FFF, 16'h0000, 13'h0000);
        send_request(REQ_READ,  14'h0155, 16'h0000, 13'h0000);  // cleared by reset
        send_request(REQ_TICK,  14'h0000, 16'h0000, 13'h0000);
        send_request(REQ_TICK,  14'h3FFF, 16'hFFFF, 13'h1FFF);  // zero rate: same spot
        send_request(REQ_SETPOS, 14'h0000, 16'h0000, 13'h1FFF);
        send_request(REQ_RDPOS, 14'h0000, 16'h0000, 13'h0000);
        send_request(REQ_TICK,  14'h0000, 16'h0000, 13'h0000);
        send_request(3'd5,      14'h3FFF, 16'hFFFF, 13'h1FFF);
        send_request(3'd6,      14'h3FFF, 16'hFFFF, 13'h1FFF);
        send_request(3'd7,      14'h3FFF, 16'hFFFF, 13'h1FFF);
        send_request(REQ_READ,  14'h3FFF, 16'h0000, 13'h0000);  // untouched by bad codes

        // --- directed: full-scale gain saturates; rounding wraps past the end
        apply_setting(16'd30000, 16'hFFFF, 16'hFFFF);
        send_request(REQ_SETPOS, 14'h0000, 16'h0000, 13'h1FFF);
        send_request(REQ_TICK,  14'h0000, 16'h0000, 13'h0000);
        send_request(REQ_RDPOS, 14'h0000, 16'h0000, 13'h0000);  // rounds to index 0
        send_request(REQ_TICK,  14'h0000, 16'h0000, 13'h0000);  // phase wraps
        send_request(REQ_RDPOS, 14'h0000, 16'h0000, 13'h0000);

        // --- random: one block of requests per setting, idle pattern by progress
        done    = 0;
        per_set = RAND_ITEMS / N_SETTINGS;
        for (int s = 0; s < N_SETTINGS; s++) begin
            apply_setting(rate_set[s], gl_set[s], gr_set[s]);
            hot_base = (s == 1) ? 13'd8160 : 13'($urandom);   // one window straddles the end
            for (int n = 0; n < per_set || (s == N_SETTINGS - 1 && done < RAND_ITEMS); ) begin
                if (done < RAND_ITEMS / 3) begin
                    src_idle = 6;
                    rcv_idle = 50;
                end else if (done < 2 * RAND_ITEMS / 3) begin
                    src_idle = 50;
                    rcv_idle = 6;
                end else begin
                    src_idle = 0;
                    rcv_idle = 0;
                end
                send_random(kind);
                if (kind <= REQ_TICK) begin   // ignored codes don't count
                    n++;
                    done++;
                end
            end
        end

        drain();
        repeat (8) @(posedge i_clk);   // catch any stray late transfer

        $display("covered %0d requests: %0d ticks, %0d saturated samples, %0d ring reads",
                 sb.n_req, sb.n_tick, sb.n_sat, sb.n_read);
        $display("over %0d rate/gain settings and three idle patterns, %0d mismatches",
                 N_SETTINGS + 2, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
